>>> rtl/sbgs_pkg.sv
package sbgs_pkg;

  // opcodes of an input request
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SAMPLE  = 2'd1;
  localparam logic [1:0] OP_COMMAND = 2'd2;

  // direction codes shared by target and motion
  localparam logic [1:0] MOVE_NONE  = 2'd0;
  localparam logic [1:0] MOVE_OPEN  = 2'd1;
  localparam logic [1:0] MOVE_CLOSE = 2'd2;
  localparam logic [1:0] MOVE_STOP  = 2'd3;

  // sensor bit positions
  localparam int SNS_OPENED  = 0;
  localparam int SNS_OPENING = 1;
  localparam int SNS_CLOSED  = 2;
  localparam int SNS_CLOSING = 3;

  // configuration register indexes
  localparam logic CFG_PRESS_DURATION = 1'b0;
  localparam logic CFG_COMMAND_OBJECT = 1'b1;

  localparam logic [7:0] PRESS_DURATION_RESET = 8'd5;
  localparam logic [7:0] COMMAND_OBJECT_RESET = 8'd0;
  localparam logic [3:0] SENSORS_RESET        = 4'hf;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] sensor_bits;
    logic [7:0] object_number;
    logic       command_value;
  } in_item_t;

  typedef struct packed {
    logic       button_out;
    logic [1:0] target_dir;
    logic [1:0] moving_dir;
  } out_item_t;

endpackage

>>> rtl/single_button_gate_sequencer.sv
// single_button_gate_sequencer: gate control through one push-button output
// each result is registered in the output stage (result register, then skid)
// one request per cycle is taken while the skid is empty; the two-entry stage
// lets input requests continue while one result waits on out_stall
// reset (rst, synchronous): no target, stopped, sensors all ones, timer zero,
// button released, press_duration 5, command_object 0, output stage empty
module single_button_gate_sequencer
  import sbgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input requests
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  // result requests
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  // configuration writes
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  typedef struct packed {
    logic [1:0] target;
    logic       press;
  } eval_t;

  // configuration registers
  logic [7:0] press_duration;
  logic [7:0] command_object;

  // gate state
  logic [1:0] target_state, target_state_next;
  logic [1:0] motion_state, motion_state_next;
  logic [3:0] last_sensors, last_sensors_next;
  logic [7:0] press_timer, press_timer_next;
  logic       button_level, button_level_next;

  // output stage
  logic       skid_valid;
  out_item_t  skid_data;
  out_item_t  result;

  logic       in_accept;
  logic       out_pop;

  // evaluation rule: decides whether the target is reached or needs a press
  function automatic eval_t evaluate(input logic [1:0] tgt, input logic [3:0] s);
    eval_t r;
    r.target = tgt;
    r.press  = 1'b0;
    case (tgt)
      MOVE_OPEN: begin
        if (s[SNS_OPENED] || s[SNS_OPENING]) r.target = MOVE_NONE;
        else r.press = 1'b1;
      end
      MOVE_CLOSE: begin
        if (s[SNS_CLOSED] || s[SNS_CLOSING]) r.target = MOVE_NONE;
        else r.press = 1'b1;
      end
      MOVE_STOP: begin
        if (s[SNS_OPENING] || s[SNS_CLOSING]) r.press = 1'b1;
        else r.target = MOVE_NONE;
      end
      default: begin
        r.press = 1'b0;
      end
    endcase
    return r;
  endfunction

  // the skid holding a result means no room for another one
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;

  // next state for the request at the input
  always_comb begin
    eval_t ev;
    logic [1:0] cmd_target;
    ev                = '0;
    cmd_target        = MOVE_NONE;
    target_state_next = target_state;
    motion_state_next = motion_state;
    last_sensors_next = last_sensors;
    press_timer_next  = press_timer;
    button_level_next = button_level;
    case (in_data.opcode)
      OP_TICK: begin
        if (press_timer != 8'd0) begin
          press_timer_next = press_timer - 8'd1;
          // timer expires on this tick
          if (press_timer == 8'd1) begin
            if (button_level) begin
              button_level_next = 1'b0;
              target_state_next = MOVE_NONE;
            end else begin
              ev = evaluate(target_state, last_sensors);
              target_state_next = ev.target;
              if (ev.press) begin
                button_level_next = 1'b1;
                press_timer_next  = press_duration;
              end
            end
          end
        end
      end
      OP_SAMPLE: begin
        if (in_data.sensor_bits != last_sensors) begin
          last_sensors_next = in_data.sensor_bits;
          if (in_data.sensor_bits[SNS_OPENING]) motion_state_next = MOVE_OPEN;
          else if (in_data.sensor_bits[SNS_CLOSING]) motion_state_next = MOVE_CLOSE;
          else motion_state_next = MOVE_STOP;
          // early release, timer becomes the settle wait
          if (press_timer != 8'd0 && button_level) begin
            button_level_next = 1'b0;
            press_timer_next  = press_duration;
          end
        end
      end
      OP_COMMAND: begin
        if (in_data.object_number == command_object) begin
          // a second command while a target is pending means stop
          if (target_state == MOVE_NONE) begin
            cmd_target = in_data.command_value ? MOVE_OPEN : MOVE_CLOSE;
          end else begin
            cmd_target = MOVE_STOP;
          end
          ev = evaluate(cmd_target, last_sensors);
          target_state_next = ev.target;
          if (ev.press) begin
            button_level_next = 1'b1;
            press_timer_next  = press_duration;
          end
        end
      end
      default: begin
        // unused opcode reports the state unchanged
        target_state_next = target_state;
      end
    endcase
  end

  assign result.button_out = button_level_next;
  assign result.target_dir = target_state_next;
  assign result.moving_dir = motion_state_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      press_duration <= PRESS_DURATION_RESET;
      command_object <= COMMAND_OBJECT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRESS_DURATION: press_duration <= cfg_data;
        CFG_COMMAND_OBJECT: command_object <= cfg_data;
        default: press_duration <= press_duration;
      endcase
    end
  end

  // gate state, updated once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      target_state <= MOVE_NONE;
      motion_state <= MOVE_STOP;
      last_sensors <= SENSORS_RESET;
      press_timer  <= 8'd0;
      button_level <= 1'b0;
    end else if (in_accept) begin
      target_state <= target_state_next;
      motion_state <= motion_state_next;
      last_sensors <= last_sensors_next;
      press_timer  <= press_timer_next;
      button_level <= button_level_next;
    end
  end

  // output stage: result register in front, skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_pop) begin
      out_valid  <= skid_valid || in_accept;
      skid_valid <= skid_valid && in_accept;
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (in_accept) skid_data <= result;
      end else if (in_accept) begin
        out_data <= result;
      end
    end else if (in_accept) begin
      skid_data <= result;
    end
  end

  // a filled skid always sits behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  // a request accepted into an empty output stage shows up next cycle
  a_result_appears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !out_valid) |=> out_valid)
    else $error("accepted request produced no result");

  // a held button is released when its press timer runs out
  a_timeout_release: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.opcode == OP_TICK && press_timer == 8'd1 && button_level)
      |=> (!button_level && target_state == MOVE_NONE))
    else $error("button not released at press timeout");

endmodule

>>> dv/single_button_gate_sequencer_tb.sv
`timescale 1ns / 1ps

module single_button_gate_sequencer_tb;
  import sbgs_pkg::*;

  // opcode 3 has no function in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // single sensor patterns
  localparam logic [3:0] SENSE_OPENED  = 4'(1 << SNS_OPENED);
  localparam logic [3:0] SENSE_OPENING = 4'(1 << SNS_OPENING);
  localparam logic [3:0] SENSE_CLOSED  = 4'(1 << SNS_CLOSED);
  localparam logic [3:0] SENSE_CLOSING = 4'(1 << SNS_CLOSING);

  // tracks the gate controller state and the results still owed by the block
  class gate_tracker;
    logic [7:0]  hold_ticks;
    logic [7:0]  listen_object;
    logic [1:0]  target;
    logic [1:0]  motion;
    logic [3:0]  sensors;
    logic [7:0]  timer;
    logic        button;
    out_item_t   awaited_outputs[$];
    int unsigned mismatches;

    function new();
      hold_ticks    = PRESS_DURATION_RESET;
      listen_object = COMMAND_OBJECT_RESET;
      target        = MOVE_NONE;
      motion        = MOVE_STOP;
      sensors       = SENSORS_RESET;
      timer         = '0;
      button        = 1'b0;
      mismatches    = 0;
    endfunction

    function void write_register(logic index, logic [7:0] value);
      if (index == CFG_PRESS_DURATION) hold_ticks = value;
      else listen_object = value;
    endfunction

    function void evaluate_target();
      logic press;
      press = 1'b0;
      case (target)
        MOVE_OPEN: begin
          if (sensors[SNS_OPENED] || sensors[SNS_OPENING]) target = MOVE_NONE;
          else press = 1'b1;
        end
        MOVE_CLOSE: begin
          if (sensors[SNS_CLOSED] || sensors[SNS_CLOSING]) target = MOVE_NONE;
          else press = 1'b1;
        end
        MOVE_STOP: begin
          if (sensors[SNS_OPENING] || sensors[SNS_CLOSING]) press = 1'b1;
          else target = MOVE_NONE;
        end
        default: ;
      endcase
      if (press) begin
        button = 1'b1;
        timer  = hold_ticks;
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t next;
      case (req.opcode)
        OP_TICK: begin
          if (timer != 0) begin
            timer = timer - 8'd1;
            if (timer == 0) begin
              if (button) begin
                button = 1'b0;
                target = MOVE_NONE;
              end else begin
                evaluate_target();
              end
            end
          end
        end
        OP_SAMPLE: begin
          if (req.sensor_bits != sensors) begin
            sensors = req.sensor_bits;
            if (sensors[SNS_OPENING]) motion = MOVE_OPEN;
            else if (sensors[SNS_CLOSING]) motion = MOVE_CLOSE;
            else motion = MOVE_STOP;
            if (timer != 0 && button) begin
              button = 1'b0;
              timer  = hold_ticks;
            end
          end
        end
        OP_COMMAND: begin
          if (req.object_number == listen_object) begin
            if (target == MOVE_NONE) target = req.command_value ? MOVE_OPEN : MOVE_CLOSE;
            else target = MOVE_STOP;
            evaluate_target();
          end
        end
        default: ;
      endcase
      next.button_out = button;
      next.target_dir = target;
      next.moving_dir = motion;
      awaited_outputs.push_back(next);
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(input out_item_t got);
      out_item_t want;
      if (awaited_outputs.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with none outstanding",
                         got.button_out, got.target_dir, got.moving_dir));
        return;
      end
      want = awaited_outputs.pop_front();
      if (got.button_out !== want.button_out)
        report($sformatf("button_out %0d, wanted %0d", got.button_out, want.button_out));
      if (got.target_dir !== want.target_dir)
        report($sformatf("target_dir %0d, wanted %0d", got.target_dir, want.target_dir));
      if (got.moving_dir !== want.moving_dir)
        report($sformatf("moving_dir %0d, wanted %0d", got.moving_dir, want.moving_dir));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;

  gate_tracker gate;
  bit          reset_done       = 1'b0;
  bit          hold_off_pending = 1'b0;
  int unsigned sender_burst     = 0;
  int unsigned receiver_burst   = 0;

  single_button_gate_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle cycles before the next request, with occasional runs of back-to-back
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic in_item_t make_request(logic [1:0] op, logic [3:0] sns,
                                            logic [7:0] obj, logic val);
    in_item_t req;
    req.opcode        = op;
    req.sensor_bits   = sns;
    req.object_number = obj;
    req.command_value = val;
    return req;
  endfunction

  // mostly ticks, clean sensor patterns and commands to the listened object;
  // fields that the opcode ignores are always random
  function automatic in_item_t random_request(logic [7:0] obj);
    in_item_t    req;
    int unsigned roll;
    roll              = $urandom_range(0, 99);
    req.sensor_bits   = 4'($urandom);
    req.object_number = 8'($urandom);
    req.command_value = 1'($urandom);
    if (roll < 45) begin
      req.opcode = OP_TICK;
    end else if (roll < 70) begin
      req.opcode = OP_SAMPLE;
      // a real gate shows one sensor at a time, or none while in between
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 4))
          0: req.sensor_bits = SENSE_OPENED;
          1: req.sensor_bits = SENSE_OPENING;
          2: req.sensor_bits = SENSE_CLOSED;
          3: req.sensor_bits = SENSE_CLOSING;
          default: req.sensor_bits = 4'h0;
        endcase
      end
    end else if (roll < 95) begin
      req.opcode = OP_COMMAND;
      if ($urandom_range(0, 9) < 8) req.object_number = obj;
    end else begin
      req.opcode = OP_UNUSED;
    end
    return req;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = draw_gap(sender_burst);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    gate.note_request(req);
  endtask

  task automatic write_register(input logic index, input logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    gate.write_register(index, value);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle();
    int unsigned spent;
    @(negedge clk);
    in_valid <= 1'b0;
    spent = 0;
    while (gate.awaited_outputs.size() != 0 && spent < 4000) begin
      @(negedge clk);
      spent++;
    end
    // margin after the last result
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] duration, input logic [7:0] object,
                           input int unsigned count, input bit hold_off);
    write_register(CFG_PRESS_DURATION, duration);
    write_register(CFG_COMMAND_OBJECT, object);
    // long receiver hold while requests keep coming, so the input backs up
    if (hold_off) hold_off_pending = 1'b1;
    repeat (count) send_request(random_request(object));
    settle();
  endtask

  // result side: random stalls, one long hold when asked
  initial begin : result_sink
    int unsigned stall_cycles;
    wait (reset_done);
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall_cycles     = 60;
      end else begin
        stall_cycles = draw_gap(receiver_burst);
      end
      if (stall_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      gate.check_result(out_data);
    end
  end

  // stimulus
  initial begin : request_source
    gate      = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = CFG_PRESS_DURATION;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst        <= 1'b0;
    reset_done = 1'b1;

    // directed part at the reset register values
    // unused opcode, unchanged first sample, a command to a foreign object
    send_request(make_request(OP_UNUSED, 4'hA, 8'hFF, 1'b1));
    send_request(make_request(OP_SAMPLE, SENSORS_RESET, 8'h00, 1'b0));
    send_request(make_request(OP_COMMAND, 4'h0, 8'hFF, 1'b1));
    // gate closed, open it: press, then opening releases the button early
    send_request(make_request(OP_SAMPLE, SENSE_CLOSED, 8'h00, 1'b0));
    send_request(make_request(OP_COMMAND, 4'hF, 8'h00, 1'b1));
    send_request(make_request(OP_SAMPLE, SENSE_OPENING, 8'hFF, 1'b1));
    // settle wait runs out, target open is already reached
    repeat (5) send_request(make_request(OP_TICK, 4'hF, 8'hFF, 1'b1));
    // close while opening presses, a second command turns into stop
    send_request(make_request(OP_COMMAND, 4'hF, 8'h00, 1'b0));
    send_request(make_request(OP_COMMAND, 4'h0, 8'h00, 1'b1));
    // press times out with the button held
    repeat (5) send_request(make_request(OP_TICK, 4'h0, 8'h00, 1'b0));
    // targets already reached are cleared at once
    send_request(make_request(OP_SAMPLE, SENSE_OPENED, 8'hFF, 1'b1));
    send_request(make_request(OP_COMMAND, 4'h0, 8'h00, 1'b1));
    send_request(make_request(OP_SAMPLE, SENSE_CLOSING, 8'h00, 1'b0));
    send_request(make_request(OP_COMMAND, 4'hF, 8'h00, 1'b0));
    // open while closing presses, then stop while closing presses again
    send_request(make_request(OP_COMMAND, 4'h0, 8'h00, 1'b1));
    send_request(make_request(OP_COMMAND, 4'hF, 8'h00, 1'b0));
    send_request(make_request(OP_SAMPLE, 4'h0, 8'hFF, 1'b0));
    repeat (5) send_request(make_request(OP_TICK, 4'hF, 8'h00, 1'b1));
    settle();

    // random phases, shortest and longest press among them;
    // zero press duration keeps a press held until a later phase presses again
    run_phase(8'd1, 8'hFF, 300, 1'b1);
    run_phase(8'd255, 8'h5A, 300, 1'b0);
    run_phase(8'd3, 8'($urandom), 300, 1'b1);
    run_phase(8'd0, 8'h81, 250, 1'b0);
    run_phase(8'd2, 8'h00, 350, 1'b0);
    run_phase(8'd5, 8'h3C, 300, 1'b0);

    if (gate.awaited_outputs.size() != 0)
      gate.report($sformatf("%0d results never arrived", gate.awaited_outputs.size()));
    if (gate.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
